>>> hdl/sllm_pkg.sv
package sllm_pkg;

    localparam int SLOTS_DEF = 32;

    localparam int CMD_W = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_TRAVERSE = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd_code;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_INS_TAKE,
        S_INS_HEAD,
        S_INS_WALK,
        S_INS_STEP,
        S_INS_LINK,
        S_INS_TIE,
        S_DEL_WALK,
        S_DEL_STEP,
        S_DEL_GETJ,
        S_DEL_RDJ,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_TRAV_RD,
        S_TRAV_EMIT,
        S_END
    } t_state;

    // link memory address sources
    typedef enum logic [1:0] {
        A_FREE,
        A_CUR,
        A_SLOT
    } t_addr_sel;

    // link memory write data sources
    typedef enum logic [1:0] {
        W_RD_LINK,
        W_LIST_HEAD,
        W_FREE_HEAD,
        W_SLOT
    } t_wdata_sel;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        t_addr_sel  rd_sel;
        logic       wr_en;
        t_addr_sel  wr_sel;
        t_wdata_sel wr_data;
        logic       val_wr;
        logic       take_free;
        logic       walk_init;
        logic       trav_init;
        logic       walk_step;
        logic       j_from_head;
        logic       j_from_rd;
        logic       head_from_rd;
        logic       head_from_j;
        logic       free_from_j;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       emit;
        t_status    emit_status;
        logic       emit_elem;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd_code cmd;
        logic      out_free;
        logic      ins_bad;
        logic      del_bad;
        logic      free_empty;
        logic      pos_one;
        logic      walk_done;
        logic      trav_last;
        logic      count_zero;
    } t_dp_stat;

endpackage

>>> hdl/sllm_datapath.sv
module sllm_datapath #(
    parameter int SLOTS = sllm_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sllm_pkg::t_dp_cmd             i_cmd,
    output sllm_pkg::t_dp_stat            o_stat,
    input  logic [sllm_pkg::CMD_W-1:0]    i_command,
    input  logic [sllm_pkg::POS_W-1:0]    i_position,
    input  logic signed [sllm_pkg::VAL_W-1:0] i_value,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [sllm_pkg::ST_W-1:0]     o_status,
    output logic signed [sllm_pkg::VAL_W-1:0] o_data,
    output logic                          o_data_valid,
    output logic [sllm_pkg::LEN_W-1:0]    o_length,
    output logic                          o_last
);

    localparam int IW = $clog2(SLOTS);
    localparam int NW = (IW + 1 > sllm_pkg::POS_W) ? IW + 1 : sllm_pkg::POS_W;
    localparam int LW = sllm_pkg::LEN_W;

    logic [IW-1:0]                 link_mem  [SLOTS];
    logic [sllm_pkg::VAL_W-1:0]    value_mem [SLOTS];
    logic [SLOTS-1:0]              r_link_vld;

    sllm_pkg::t_cmd_code           r_cmd;
    logic [sllm_pkg::POS_W-1:0]    r_pos;
    logic [sllm_pkg::VAL_W-1:0]    r_val;
    logic [IW-1:0]                 r_free_head;
    logic [IW-1:0]                 r_list_head;
    logic [IW-1:0]                 r_count;
    logic [IW-1:0]                 n_count;
    logic [IW-1:0]                 r_cur;
    logic [IW-1:0]                 r_slot;
    logic [NW-1:0]                 r_n;
    logic [IW-1:0]                 r_rd_link;
    logic [sllm_pkg::VAL_W-1:0]    r_rd_value;
    logic                          r_out_valid;

    logic [IW-1:0]                 rd_addr;
    logic [IW-1:0]                 wr_addr;
    logic [IW-1:0]                 wr_data;
    logic [NW-1:0]                 pos_ext;
    logic [NW-1:0]                 cnt_ext;
    logic [LW+IW-1:0]              len_wide;
    logic                          out_free;

    // free chain after reset: 1 -> 2 -> ... -> SLOTS-2 -> 0
    function automatic logic [IW-1:0] reset_link(input logic [IW-1:0] a);
        if (a != '0 && {1'b0, a} <= (IW+1)'(SLOTS - 3)) begin
            return IW'({1'b0, a} + 1'b1);
        end
        return '0;
    endfunction

    always_comb begin
        unique case (i_cmd.rd_sel)
            sllm_pkg::A_FREE: rd_addr = r_free_head;
            sllm_pkg::A_CUR:  rd_addr = r_cur;
            sllm_pkg::A_SLOT: rd_addr = r_slot;
            default:          rd_addr = r_cur;
        endcase
        unique case (i_cmd.wr_sel)
            sllm_pkg::A_FREE: wr_addr = r_free_head;
            sllm_pkg::A_CUR:  wr_addr = r_cur;
            sllm_pkg::A_SLOT: wr_addr = r_slot;
            default:          wr_addr = r_cur;
        endcase
        unique case (i_cmd.wr_data)
            sllm_pkg::W_RD_LINK:   wr_data = r_rd_link;
            sllm_pkg::W_LIST_HEAD: wr_data = r_list_head;
            sllm_pkg::W_FREE_HEAD: wr_data = r_free_head;
            sllm_pkg::W_SLOT:      wr_data = r_slot;
            default:               wr_data = r_rd_link;
        endcase
    end

    // link and value memories, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.val_wr) begin
            value_mem[r_free_head] <= r_val;
        end
        if (i_cmd.rd_en) begin
            r_rd_link  <= r_link_vld[rd_addr] ? link_mem[rd_addr] : reset_link(rd_addr);
            r_rd_value <= value_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_link_vld[wr_addr] <= 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= IW'(1);
            r_list_head <= '0;
            r_count     <= '0;
        end else begin
            if (i_cmd.take_free) begin
                r_free_head <= r_rd_link;
            end else if (i_cmd.free_from_j) begin
                r_free_head <= r_slot;
            end
            if (i_cmd.head_from_rd) begin
                r_list_head <= r_rd_link;
            end else if (i_cmd.head_from_j) begin
                r_list_head <= r_slot;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= sllm_pkg::t_cmd_code'(i_command);
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.walk_init || i_cmd.trav_init) begin
            r_cur <= r_list_head;
            r_n   <= i_cmd.walk_init ? NW'(2) : '0;
        end else if (i_cmd.walk_step) begin
            r_cur <= r_rd_link;
            r_n   <= r_n + 1'b1;
        end
        if (i_cmd.take_free) begin
            r_slot <= r_free_head;
        end else if (i_cmd.j_from_head) begin
            r_slot <= r_list_head;
        end else if (i_cmd.j_from_rd) begin
            r_slot <= r_rd_link;
        end
    end

    // result register
    assign out_free = !r_out_valid || !i_stall;
    assign len_wide = {{LW{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status     <= i_cmd.emit_status;
            o_data       <= i_cmd.emit_elem ? r_rd_value : '0;
            o_data_valid <= i_cmd.emit_elem;
            o_length     <= len_wide[LW-1:0];
            o_last       <= i_cmd.emit_elem ? o_stat.trav_last : 1'b1;
        end
    end

    assign o_valid = r_out_valid;

    assign pos_ext = NW'(r_pos);
    assign cnt_ext = NW'(r_count);

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.out_free   = out_free;
        o_stat.ins_bad    = (r_pos == '0) || (pos_ext > cnt_ext + 1'b1);
        o_stat.del_bad    = (r_pos == '0) || (pos_ext > cnt_ext);
        o_stat.free_empty = (r_free_head == '0);
        o_stat.pos_one    = (r_pos == sllm_pkg::POS_W'(1));
        o_stat.walk_done  = (r_n == pos_ext);
        o_stat.trav_last  = ((r_n + 1'b1) == cnt_ext);
        o_stat.count_zero = (r_count == '0);
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (IW+1)'(r_count) <= (IW+1)'(SLOTS - 2))
        else $error("element count above capacity");

    a_heads_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head != r_list_head) || (r_free_head == '0))
        else $error("free chain and list share a head slot");

    a_insert_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.val_wr |-> (r_free_head != '0) && i_cmd.take_free)
        else $error("value written without a free slot taken");

endmodule

>>> hdl/sllm_ctrl.sv
module sllm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sllm_pkg::t_dp_stat i_stat,
    output sllm_pkg::t_dp_cmd  o_cmd
);

    sllm_pkg::t_state r_state;
    sllm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sllm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != sllm_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            sllm_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sllm_pkg::S_DECODE;
                end
            end
            sllm_pkg::S_DECODE: begin
                unique case (i_stat.cmd)
                    sllm_pkg::CMD_INSERT: begin
                        if (i_stat.ins_bad || i_stat.free_empty) begin
                            if (i_stat.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = i_stat.ins_bad ? sllm_pkg::ST_RANGE
                                                                   : sllm_pkg::ST_FULL;
                                n_state           = sllm_pkg::S_IDLE;
                            end
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = sllm_pkg::A_FREE;
                            n_state      = sllm_pkg::S_INS_TAKE;
                        end
                    end
                    sllm_pkg::CMD_DELETE: begin
                        if (i_stat.del_bad) begin
                            if (i_stat.out_free) begin
                                o_cmd.emit        = 1'b1;
                                o_cmd.emit_status = sllm_pkg::ST_RANGE;
                                n_state           = sllm_pkg::S_IDLE;
                            end
                        end else if (i_stat.pos_one) begin
                            o_cmd.j_from_head = 1'b1;
                            n_state           = sllm_pkg::S_DEL_RDJ;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = sllm_pkg::S_DEL_WALK;
                        end
                    end
                    sllm_pkg::CMD_TRAVERSE: begin
                        if (!i_stat.count_zero) begin
                            o_cmd.trav_init = 1'b1;
                            n_state         = sllm_pkg::S_TRAV_RD;
                        end else if (i_stat.out_free) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = sllm_pkg::ST_OK;
                            n_state           = sllm_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = sllm_pkg::ST_OK;
                            n_state           = sllm_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            sllm_pkg::S_INS_TAKE: begin
                o_cmd.take_free = 1'b1;
                o_cmd.val_wr    = 1'b1;
                if (i_stat.pos_one) begin
                    n_state = sllm_pkg::S_INS_HEAD;
                end else begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = sllm_pkg::S_INS_WALK;
                end
            end
            sllm_pkg::S_INS_HEAD: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_sel      = sllm_pkg::A_SLOT;
                o_cmd.wr_data     = sllm_pkg::W_LIST_HEAD;
                o_cmd.head_from_j = 1'b1;
                n_state           = sllm_pkg::S_END;
            end
            sllm_pkg::S_INS_WALK: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = sllm_pkg::A_CUR;
                n_state      = i_stat.walk_done ? sllm_pkg::S_INS_LINK : sllm_pkg::S_INS_STEP;
            end
            sllm_pkg::S_INS_STEP: begin
                o_cmd.walk_step = 1'b1;
                n_state         = sllm_pkg::S_INS_WALK;
            end
            sllm_pkg::S_INS_LINK: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = sllm_pkg::A_SLOT;
                o_cmd.wr_data = sllm_pkg::W_RD_LINK;
                n_state       = sllm_pkg::S_INS_TIE;
            end
            sllm_pkg::S_INS_TIE: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = sllm_pkg::A_CUR;
                o_cmd.wr_data = sllm_pkg::W_SLOT;
                n_state       = sllm_pkg::S_END;
            end
            sllm_pkg::S_DEL_WALK: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = sllm_pkg::A_CUR;
                n_state      = i_stat.walk_done ? sllm_pkg::S_DEL_GETJ : sllm_pkg::S_DEL_STEP;
            end
            sllm_pkg::S_DEL_STEP: begin
                o_cmd.walk_step = 1'b1;
                n_state         = sllm_pkg::S_DEL_WALK;
            end
            sllm_pkg::S_DEL_GETJ: begin
                o_cmd.j_from_rd = 1'b1;
                n_state         = sllm_pkg::S_DEL_RDJ;
            end
            sllm_pkg::S_DEL_RDJ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = sllm_pkg::A_SLOT;
                n_state      = sllm_pkg::S_DEL_UNLINK;
            end
            sllm_pkg::S_DEL_UNLINK: begin
                if (i_stat.pos_one) begin
                    o_cmd.head_from_rd = 1'b1;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = sllm_pkg::A_CUR;
                    o_cmd.wr_data = sllm_pkg::W_RD_LINK;
                end
                n_state = sllm_pkg::S_DEL_FREE;
            end
            sllm_pkg::S_DEL_FREE: begin
                o_cmd.wr_en       = 1'b1;
                o_cmd.wr_sel      = sllm_pkg::A_SLOT;
                o_cmd.wr_data     = sllm_pkg::W_FREE_HEAD;
                o_cmd.free_from_j = 1'b1;
                n_state           = sllm_pkg::S_END;
            end
            sllm_pkg::S_TRAV_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = sllm_pkg::A_CUR;
                n_state      = sllm_pkg::S_TRAV_EMIT;
            end
            sllm_pkg::S_TRAV_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = sllm_pkg::ST_OK;
                    o_cmd.emit_elem   = 1'b1;
                    o_cmd.walk_step   = 1'b1;
                    n_state = i_stat.trav_last ? sllm_pkg::S_IDLE : sllm_pkg::S_TRAV_RD;
                end
            end
            sllm_pkg::S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = sllm_pkg::ST_OK;
                    o_cmd.cnt_inc     = (i_stat.cmd == sllm_pkg::CMD_INSERT);
                    o_cmd.cnt_dec     = (i_stat.cmd == sllm_pkg::CMD_DELETE);
                    n_state           = sllm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sllm_pkg::S_IDLE;
            end
        endcase
    end

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result issued into a full output register");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == sllm_pkg::S_DECODE))
        else $error("accepted beat did not reach decode");

endmodule

>>> hdl/static_linked_list_manager.sv
// Linked list held in a slot array with a free chain of unused slots. Each input beat
// is one command: insert a value at a 1-based position, delete the element at a position,
// or traverse the list. Insert and delete give one result beat (status ok, position out of
// range, or no free slot) with the new length; traverse gives one beat per element in list
// order with last set on the final one, or a single empty beat when the list is empty.
// Command code 3 is answered like an empty traverse. Slots 1..SLOTS-2 hold elements; slot
// 0 marks the end of a chain. There is no clearing pass: the block takes commands from the
// first cycle after reset. One command is worked at a time; o_stall is high from accept
// until its last result is issued. Every link hop is a read of the link memory followed
// by a pointer update.
module static_linked_list_manager #(
    parameter int SLOTS = sllm_pkg::SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command beats
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sllm_pkg::CMD_W-1:0]        i_command,
    input  logic [sllm_pkg::POS_W-1:0]        i_position,
    input  logic signed [sllm_pkg::VAL_W-1:0] i_value,
    // result beats
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sllm_pkg::ST_W-1:0]         o_status,
    output logic signed [sllm_pkg::VAL_W-1:0] o_data,
    output logic                              o_data_valid,
    output logic [sllm_pkg::LEN_W-1:0]        o_length,
    output logic                              o_last
);

    sllm_pkg::t_dp_cmd  dp_cmd;
    sllm_pkg::t_dp_stat dp_stat;

    // sequencer: decodes the command and steps through the link walk
    sllm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // slot memories, head pointers, element count and the result register
    sllm_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_value      (i_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_data_valid (o_data_valid),
        .o_length     (o_length),
        .o_last       (o_last)
    );

endmodule

>>> tb/static_linked_list_manager_tb.sv
`timescale 1ns / 100ps

module static_linked_list_manager_tb;

    // Usable slots are 1..SLOTS-2: slot 0 ends a chain, the top slot is never handed out.
    localparam int NSLOT       = sllm_pkg::SLOTS_DEF;
    localparam int MAX_LEN     = NSLOT - 2;
    // Longest legal quiet stretch is the receiver hold-off plus one command plus a full
    // gap on each side; this limit is several times that.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 150;

    typedef struct {
        sllm_pkg::t_cmd_code        cmd;
        logic [sllm_pkg::POS_W-1:0] pos;
        logic [sllm_pkg::VAL_W-1:0] val;
    } t_list_cmd;

    typedef struct {
        sllm_pkg::t_status          status;
        logic [sllm_pkg::VAL_W-1:0] data;
        logic                       dv;
        logic [sllm_pkg::LEN_W-1:0] len;
        logic                       last;
    } t_list_beat;

    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_valid      = 1'b0;
    logic                              o_stall;
    logic [sllm_pkg::CMD_W-1:0]        i_command    = sllm_pkg::CMD_INSERT;
    logic [sllm_pkg::POS_W-1:0]        i_position   = '0;
    logic signed [sllm_pkg::VAL_W-1:0] i_value      = '0;
    logic                              o_valid;
    logic                              i_stall      = 1'b0;
    logic [sllm_pkg::ST_W-1:0]         o_status;
    logic signed [sllm_pkg::VAL_W-1:0] o_data;
    logic                              o_data_valid;
    logic [sllm_pkg::LEN_W-1:0]        o_length;
    logic                              o_last;

    static_linked_list_manager dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_data_valid (o_data_valid),
        .o_length     (o_length),
        .o_last       (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_list_cmd  cmd_q[$];       // commands not yet offered to the block
    t_list_beat beats_due[$];   // result beats predicted, oldest first
    int         cmds_taken = 0; // accepted command beats (NBA only, read by other blocks)
    int         n_cmds     = 0; // commands in the plan
    int         bad_beats  = 0;
    int         quiet      = 0;
    int         hold_left  = 0;
    logic       hold_used  = 1'b0;
    logic       rx_hold;
    int         tx_gap     = 0;
    int         rx_gap     = 0;
    int         plan_len   = 0; // list length as the command plan sees it
    t_list_cmd  tx_item;

    // ------------------------------------------------------------------
    // List predictor: own copy of the slot array, links and heads
    // ------------------------------------------------------------------
    logic [sllm_pkg::VAL_W-1:0] ls_value [NSLOT];
    logic [sllm_pkg::POS_W-1:0] ls_link  [NSLOT];
    logic [sllm_pkg::POS_W-1:0] ls_free;
    logic [sllm_pkg::POS_W-1:0] ls_head;
    logic [sllm_pkg::LEN_W-1:0] ls_count;

    task automatic clear_list();
        for (int i = 0; i < NSLOT; i++) begin
            ls_value[i] = '0;
            ls_link[i]  = '0;
        end
        // free chain 1 -> 2 -> ... -> SLOTS-2 -> end
        for (int i = 1; i < NSLOT - 2; i++) ls_link[i] = sllm_pkg::POS_W'(i + 1);
        ls_free  = 1;
        ls_head  = 0;
        ls_count = 0;
    endtask

    task automatic push_beat(input sllm_pkg::t_status st,
                             input logic [sllm_pkg::VAL_W-1:0] d,
                             input logic dv, input logic last);
        t_list_beat b;
        b.status = st;
        b.data   = d;
        b.dv     = dv;
        b.len    = ls_count;
        b.last   = last;
        beats_due.push_back(b);
    endtask

    // slot holding element pos-1 (pos >= 2)
    function automatic logic [sllm_pkg::POS_W-1:0] slot_before(
        input logic [sllm_pkg::POS_W-1:0] pos);
        logic [sllm_pkg::POS_W-1:0] k;
        k = ls_head;
        for (int n = 2; n < pos; n++) k = ls_link[k];
        return k;
    endfunction

    task automatic run_list_cmd(input sllm_pkg::t_cmd_code cmd,
                                input logic [sllm_pkg::POS_W-1:0] pos,
                                input logic [sllm_pkg::VAL_W-1:0] val);
        logic [sllm_pkg::POS_W-1:0] j;
        logic [sllm_pkg::POS_W-1:0] k;
        case (cmd)
            sllm_pkg::CMD_INSERT: begin
                // range check wins over the full check
                if (pos < 1 || pos > ls_count + 1) begin
                    push_beat(sllm_pkg::ST_RANGE, '0, 1'b0, 1'b1);
                end else if (ls_free == 0) begin
                    push_beat(sllm_pkg::ST_FULL, '0, 1'b0, 1'b1);
                end else begin
                    j           = ls_free;
                    ls_free     = ls_link[j];
                    ls_value[j] = val;
                    if (pos == 1) begin
                        ls_link[j] = ls_head;
                        ls_head    = j;
                    end else begin
                        k          = slot_before(pos);
                        ls_link[j] = ls_link[k];
                        ls_link[k] = j;
                    end
                    ls_count++;
                    push_beat(sllm_pkg::ST_OK, '0, 1'b0, 1'b1);
                end
            end
            sllm_pkg::CMD_DELETE: begin
                if (pos < 1 || pos > ls_count) begin
                    push_beat(sllm_pkg::ST_RANGE, '0, 1'b0, 1'b1);
                end else begin
                    if (pos == 1) begin
                        j       = ls_head;
                        ls_head = ls_link[j];
                    end else begin
                        k          = slot_before(pos);
                        j          = ls_link[k];
                        ls_link[k] = ls_link[j];
                    end
                    // freed slot goes to the head of the free chain
                    ls_link[j] = ls_free;
                    ls_free    = j;
                    ls_count--;
                    push_beat(sllm_pkg::ST_OK, '0, 1'b0, 1'b1);
                end
            end
            sllm_pkg::CMD_TRAVERSE: begin
                if (ls_count == 0) begin
                    push_beat(sllm_pkg::ST_OK, '0, 1'b0, 1'b1);
                end else begin
                    k = ls_head;
                    for (int n = 0; n < ls_count; n++) begin
                        push_beat(sllm_pkg::ST_OK, ls_value[k], 1'b1, (n + 1 == ls_count));
                        k = ls_link[k];
                    end
                end
            end
            default: begin
                // unused code: answered like an empty traverse
                push_beat(sllm_pkg::ST_OK, '0, 1'b0, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Idle draws; every 4th stretch of 50 commands runs with no idling
    // ------------------------------------------------------------------
    function automatic int pick_wait();
        if ((cmds_taken / 50) % 4 == 2) return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 18);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            clear_list();
        end else begin
            if (i_valid && !o_stall) begin
                run_list_cmd(sllm_pkg::t_cmd_code'(i_command), i_position, i_value);
                cmds_taken <= cmds_taken + 1;
                tx_gap = pick_wait();
            end
            if (i_valid && o_stall) begin
                // stalled beat holds its payload
            end else if (tx_gap > 0) begin
                i_valid <= 1'b0;
                tx_gap--;
            end else if (cmd_q.size() != 0) begin
                tx_item = cmd_q.pop_front();
                i_command  <= tx_item.cmd;
                i_position <= tx_item.pos;
                i_value    <= tx_item.val;
                i_valid    <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall
    // ------------------------------------------------------------------
    task automatic flag_bad(input string msg);
        bad_beats++;
        if (bad_beats <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_result_beat();
        t_list_beat w;
        if (beats_due.size() == 0) begin
            flag_bad($sformatf("unexpected beat st=%0d data=%h dv=%0d len=%0d last=%0d",
                               o_status, o_data, o_data_valid, o_length, o_last));
        end else begin
            w = beats_due.pop_front();
            if (o_status !== w.status || o_data !== w.data || o_data_valid !== w.dv ||
                o_length !== w.len || o_last !== w.last)
                flag_bad($sformatf({"mismatch: want st=%0d data=%h dv=%0d len=%0d last=%0d",
                                    " got st=%0d data=%h dv=%0d len=%0d last=%0d"},
                                   w.status, w.data, w.dv, w.len, w.last,
                                   o_status, o_data, o_data_valid, o_length, o_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                check_result_beat();
                rx_gap = pick_wait();
            end
            if (rx_hold || rx_gap > 0) begin
                i_stall <= 1'b1;
                if (rx_gap > 0) rx_gap--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // One long hold-off mid-run: output backs up and the block stalls its command input
    // while the driver keeps offering.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && cmds_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end
    assign rx_hold = (hold_left != 0);

    // Watchdog: ends the run after too long with no beat on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("static_linked_list_manager_tb: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // Command plan
    // ------------------------------------------------------------------
    // plan_len tracks only the length so positions can be aimed in or out of range
    task automatic add_cmd(input sllm_pkg::t_cmd_code cmd, input int pos,
                           input logic [sllm_pkg::VAL_W-1:0] val);
        t_list_cmd c;
        c.cmd = cmd;
        c.pos = sllm_pkg::POS_W'(pos);
        c.val = val;
        cmd_q.push_back(c);
        if (cmd == sllm_pkg::CMD_INSERT && c.pos >= 1 && c.pos <= plan_len + 1 &&
            plan_len < MAX_LEN)
            plan_len++;
        else if (cmd == sllm_pkg::CMD_DELETE && c.pos >= 1 && c.pos <= plan_len)
            plan_len--;
    endtask

    function automatic logic [sllm_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // head, tail, or anywhere between
    function automatic int good_pos(input int hi);
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return hi;
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    // zero or above the legal range (lo is the first illegal position)
    function automatic int bad_pos(input int lo);
        if (lo > 31 || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(lo, 31);
    endfunction

    task automatic add_random(input int w_ins, input int w_del);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            // noise: any code, any position
            add_cmd(sllm_pkg::t_cmd_code'($urandom_range(0, 3)), $urandom_range(0, 31),
                    $urandom);
        end else if (r < 6 + w_ins) begin
            add_cmd(sllm_pkg::CMD_INSERT,
                    ($urandom_range(0, 9) < 8) ? good_pos(plan_len + 1) : bad_pos(plan_len + 2),
                    rand_value());
        end else if (r < 6 + w_ins + w_del) begin
            add_cmd(sllm_pkg::CMD_DELETE,
                    (plan_len != 0 && $urandom_range(0, 9) < 8) ? good_pos(plan_len)
                                                               : bad_pos(plan_len + 1),
                    $urandom);
        end else begin
            add_cmd(sllm_pkg::CMD_TRAVERSE, $urandom_range(0, 31), $urandom);
        end
    endtask

    initial begin
        // directed: empty list corners
        add_cmd(sllm_pkg::CMD_TRAVERSE, 0, '0);              // empty traverse
        add_cmd(sllm_pkg::CMD_NONE, 1, 32'h1234_5678);       // unused code on empty list
        add_cmd(sllm_pkg::CMD_DELETE, 1, '0);                // delete from empty list
        add_cmd(sllm_pkg::CMD_INSERT, 0, 32'h5555_5555);     // position zero
        add_cmd(sllm_pkg::CMD_INSERT, 2, 32'haaaa_aaaa);     // past the end of an empty list
        // build head, middle and tail with extreme values
        add_cmd(sllm_pkg::CMD_INSERT, 1, 32'h7fff_ffff);
        add_cmd(sllm_pkg::CMD_INSERT, 1, 32'h8000_0000);
        add_cmd(sllm_pkg::CMD_INSERT, 3, 32'hffff_ffff);
        add_cmd(sllm_pkg::CMD_INSERT, 2, 32'h0000_0000);
        add_cmd(sllm_pkg::CMD_INSERT, 5, 32'h1234_5678);     // append at length+1
        add_cmd(sllm_pkg::CMD_INSERT, 7, 32'h0bad_0bad);     // beyond length+1
        add_cmd(sllm_pkg::CMD_TRAVERSE, 31, '1);
        add_cmd(sllm_pkg::CMD_DELETE, 0, '0);
        add_cmd(sllm_pkg::CMD_DELETE, 6, '0);                // one past the end
        add_cmd(sllm_pkg::CMD_DELETE, 5, '0);                // tail
        add_cmd(sllm_pkg::CMD_DELETE, 2, '0);                // middle
        add_cmd(sllm_pkg::CMD_DELETE, 1, '0);                // head
        add_cmd(sllm_pkg::CMD_TRAVERSE, 0, '0);
        add_cmd(sllm_pkg::CMD_NONE, 31, '1);                 // unused code with elements
        add_cmd(sllm_pkg::CMD_INSERT, 31, '1);
        add_cmd(sllm_pkg::CMD_DELETE, 31, '1);
        add_cmd(sllm_pkg::CMD_TRAVERSE, 0, '0);

        // random: mixed, then fill past full (no-free-slot hits), drain, mixed again
        repeat (100) add_random(44, 32);
        repeat (60)  add_random(80, 6);
        repeat (55)  add_random(12, 74);
        repeat (35)  add_random(44, 32);
        n_cmds = cmd_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every command accepted; its beats are predicted at the accepting edge
        while (cmds_taken != n_cmds) @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
        // catch any stray beat after the last one
        repeat (80) @(posedge i_clk);

        if (bad_beats == 0 && beats_due.size() == 0) begin
            $display("static_linked_list_manager_tb: done, clean");
        end else begin
            $display("static_linked_list_manager_tb: done, errors");
        end
        $finish;
    end

endmodule
